[hdl/kied_pkg.sv]
package kied_pkg;

  typedef enum logic [1:0] {
    MODE_DOOR   = 2'd0,
    MODE_SWITCH = 2'd1,
    MODE_PUSH   = 2'd2,
    MODE_MOTION = 2'd3
  } kied_mode_t;

  // register indexes on the configuration channel
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_ENABLED   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOT_INVERTED    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_DEBOUNCE   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DEBOUNCE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_DEBOUNCE    = 4'd7;

  localparam logic [31:0] REPEAT_MS   = 32'd300;
  localparam logic [6:0]  TENTH_MS    = 7'd100;
  localparam logic [7:0]  LOW6_MASK   = 8'h3F;
  localparam logic [7:0]  LP_SENTINEL = 8'hFF;
  localparam logic [7:0]  LP_SUBST    = 8'd10;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] time_ms;
    logic [7:0]  channel_in;
    logic        bus_blocked;
  } kied_sample_t;

  typedef struct packed {
    logic [7:0] channel_out;
    logic [7:0] key_number;
    logic       long_press;
  } kied_evt_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } kied_cfg_wr_t;

  typedef struct packed {
    kied_mode_t  input_mode;
    logic        input_enabled;
    logic        not_inverted;
    logic        active_high;
    logic [7:0]  long_press_tenths;
    logic [15:0] door_debounce_ms;
    logic [15:0] switch_debounce_ms;
    logic [15:0] key_debounce_ms;
  } kied_cfg_t;

endpackage

[hdl/kied_stream_if.sv]
interface kied_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/kied_cfg_regs.sv]
module kied_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  kied_pkg::kied_cfg_wr_t wr,
  output kied_pkg::kied_cfg_t   cfg
);
  import kied_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_mode         <= MODE_PUSH;
      cfg.input_enabled      <= 1'b1;
      cfg.not_inverted       <= 1'b1;
      cfg.active_high        <= 1'b0;
      cfg.long_press_tenths  <= 8'd10;
      cfg.door_debounce_ms   <= 16'd200;
      cfg.switch_debounce_ms <= 16'd100;
      cfg.key_debounce_ms    <= 16'd50;
    end else if (wr_en) begin
      case (wr.index)
        CFG_INPUT_MODE:      cfg.input_mode         <= kied_mode_t'(wr.data[1:0]);
        CFG_INPUT_ENABLED:   cfg.input_enabled      <= wr.data[0];
        CFG_NOT_INVERTED:    cfg.not_inverted       <= wr.data[0];
        CFG_ACTIVE_HIGH:     cfg.active_high        <= wr.data[0];
        CFG_LONG_PRESS:      cfg.long_press_tenths  <= wr.data[7:0];
        CFG_DOOR_DEBOUNCE:   cfg.door_debounce_ms   <= wr.data;
        CFG_SWITCH_DEBOUNCE: cfg.switch_debounce_ms <= wr.data;
        CFG_KEY_DEBOUNCE:    cfg.key_debounce_ms    <= wr.data;
        default: ;
      endcase
    end
  end
endmodule

[hdl/kied_step.sv]
module kied_step (
  input  logic                  clk,
  input  logic                  rst,
  input  kied_pkg::kied_cfg_t   cfg,
  input  logic                  step,
  input  kied_pkg::kied_sample_t item,
  output logic                  emit_valid,
  output kied_pkg::kied_evt_t   emit_data
);
  import kied_pkg::*;

  logic [31:0] press_start_time, press_start_time_next;
  logic [7:0]  press_counter, press_counter_next;
  logic [31:0] last_long_time, last_long_time_next;
  logic        last_stable_level, last_stable_level_next;

  logic [31:0] now, d_start, d_long;
  logic        lvl, busy;
  logic [7:0]  tenths, cnt_fix, cnt_inc, fix_inc;
  logic [14:0] long_thr;

  always_comb begin
    now      = (item.time_ms == 32'd0) ? 32'd1 : item.time_ms;
    lvl      = item.raw_level ^ ~cfg.not_inverted ^ cfg.active_high;
    busy     = item.bus_blocked;
    d_start  = now - press_start_time;
    d_long   = now - last_long_time;
    tenths   = (cfg.long_press_tenths == LP_SENTINEL) ? LP_SUBST : cfg.long_press_tenths;
    long_thr = 15'(tenths) * 15'(TENTH_MS);
    // counter correction used by the modes that can be held by a busy bus
    cnt_fix  = ((press_counter & LOW6_MASK) == 8'd0) ? 8'd1 : press_counter;
    cnt_inc  = press_counter + 8'd1;
    fix_inc  = cnt_fix + 8'd1;

    press_start_time_next  = press_start_time;
    press_counter_next     = press_counter;
    last_long_time_next    = last_long_time;
    last_stable_level_next = last_stable_level;
    emit_valid             = 1'b0;
    emit_data.channel_out  = item.channel_in;
    emit_data.key_number   = press_counter;
    emit_data.long_press   = 1'b0;

    if (cfg.input_enabled) begin
      case (cfg.input_mode)
        MODE_DOOR: begin
          if (lvl != last_stable_level) begin
            if (press_start_time == 32'd0) begin
              press_start_time_next = now;
            end else if (d_start >= {16'd0, cfg.door_debounce_ms}) begin
              press_counter_next = cnt_fix;
              if (!busy) begin
                press_counter_next     = fix_inc;
                last_stable_level_next = lvl;
                emit_valid             = 1'b1;
                emit_data.key_number   = cnt_fix;
                emit_data.long_press   = ~lvl;
              end
            end
          end else begin
            press_start_time_next = 32'd0;
          end
        end
        MODE_SWITCH: begin
          if (lvl) begin
            if (press_start_time == 32'd0) begin
              press_start_time_next = now;
            end else if (d_start >= {16'd0, cfg.switch_debounce_ms} &&
                         last_long_time == 32'd0) begin
              press_counter_next   = cnt_inc;
              last_long_time_next  = now;
              emit_valid           = 1'b1;
              emit_data.key_number = cnt_inc;
            end
          end else begin
            press_start_time_next = 32'd0;
            if (last_long_time != 32'd0) begin
              press_counter_next   = cnt_inc;
              last_long_time_next  = 32'd0;
              emit_valid           = 1'b1;
              emit_data.key_number = cnt_inc;
            end
          end
        end
        MODE_PUSH: begin
          if (lvl) begin
            if (press_start_time != 32'd0) begin
              press_start_time_next = 32'd0;
              if (d_start >= {16'd0, cfg.key_debounce_ms} && last_long_time == 32'd0) begin
                press_counter_next   = cnt_inc;
                emit_valid           = 1'b1;
                emit_data.key_number = cnt_inc;
              end
            end
          end else if (press_start_time != 32'd0) begin
            if (last_long_time != 32'd0) begin
              // repeat of a held long press
              if (d_long >= REPEAT_MS) begin
                last_long_time_next  = now;
                emit_valid           = 1'b1;
                emit_data.long_press = 1'b1;
              end
            end else if (d_start >= {17'd0, long_thr}) begin
              press_counter_next   = cnt_inc;
              last_long_time_next  = now;
              emit_valid           = 1'b1;
              emit_data.key_number = cnt_inc;
              emit_data.long_press = 1'b1;
            end
          end else begin
            press_start_time_next = now;
            last_long_time_next   = 32'd0;
          end
        end
        default: begin
          if (lvl) begin
            if (press_start_time == 32'd0) begin
              press_start_time_next = now;
            end else if (d_start >= {16'd0, cfg.switch_debounce_ms} &&
                         last_long_time == 32'd0) begin
              press_counter_next = cnt_fix;
              if (!busy) begin
                press_counter_next   = fix_inc;
                last_long_time_next  = now;
                emit_valid           = 1'b1;
                emit_data.key_number = cnt_fix;
              end
            end
          end else begin
            last_long_time_next   = 32'd0;
            press_start_time_next = 32'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start_time  <= 32'd0;
      press_counter     <= 8'd0;
      last_long_time    <= 32'd0;
      last_stable_level <= 1'b0;
    end else if (step) begin
      press_start_time  <= press_start_time_next;
      press_counter     <= press_counter_next;
      last_long_time    <= last_long_time_next;
      last_stable_level <= last_stable_level_next;
    end
  end
endmodule

[hdl/key_input_event_debouncer.sv]
// channel   dir  payload         transfer
// sample    in   kied_sample_t   sample.valid & sample.ready
// evt       out  kied_evt_t      evt.valid & evt.ready
// cfg       in   kied_cfg_wr_t   cfg.valid & cfg.ready (always ready)
//
// one sample per clock while evt is not stalled; from transfer to event a sample
// passes a sample register, then the step logic into the event register
// the key state updates when a sample leaves the sample register
// a stalled evt holds the event register and, once the sample register is
// full, stalls sample; rst is synchronous and clears state and config
module key_input_event_debouncer (
  input  logic clk,
  input  logic rst,
  kied_stream_if.sink   sample,
  kied_stream_if.source evt,
  kied_stream_if.sink   cfg
);
  import kied_pkg::*;

  kied_cfg_t    cfg_q;
  kied_sample_t item;
  logic         item_valid;
  logic         advance;
  logic         emit_valid;
  kied_evt_t    emit_data;

  // config writes land at once; the user must send them only while the block is idle, the block does not enforce it
  assign cfg.ready = 1'b1;

  kied_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid),
    .wr    (cfg.data),
    .cfg   (cfg_q)
  );

  // the sample moves on when the event register is free or being emptied
  assign advance      = item_valid && (!evt.valid || evt.ready);
  assign sample.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample.ready) begin
      item_valid <= sample.valid;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      item <= sample.data;
    end
  end

  kied_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .step       (advance),
    .item       (item),
    .emit_valid (emit_valid),
    .emit_data  (emit_data)
  );

  // event register; samples with no event just leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (advance) begin
      evt.valid <= emit_valid;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      evt.data <= emit_data;
    end
  end
endmodule

[sim/tb_key_input_event_debouncer.sv]
`timescale 1ns / 100ps

module tb_key_input_event_debouncer;
  import kied_pkg::*;

  // cycles with no transfer on any channel before the run is called hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // sample register plus event register, with margin
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned END_CYCLES     = 8;
  localparam int unsigned PHASE_ITEMS    = 50;
  localparam int unsigned LOCKED_ITEMS   = 10;
  // sender holds off until every event is back this often
  localparam int unsigned DRAIN_EVERY    = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kied_stream_if #(.T(kied_sample_t)) sample_if ();
  kied_stream_if #(.T(kied_evt_t))    evt_if ();
  kied_stream_if #(.T(kied_cfg_wr_t)) cfg_if ();

  key_input_event_debouncer dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .evt    (evt_if),
    .cfg    (cfg_if)
  );

  // shadow copy of the configuration and key state, updated on transfers
  kied_cfg_t   shadow_cfg;
  logic [31:0] key_press_start;
  logic [7:0]  key_count;
  logic [31:0] key_last_long;
  logic        key_stable_level;

  // events predicted but not yet seen on evt, oldest first
  kied_evt_t   pending_events[$];

  int unsigned err_count       = 0;
  int unsigned idle_cycles     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned idle_phase      = 0;

  // stimulus side: settings last written and the running timestamp
  kied_cfg_t   cur_cfg;
  logic [31:0] stamp_ms;
  logic        pin_level = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // key event prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_key_model();
    shadow_cfg.input_mode         = MODE_PUSH;
    shadow_cfg.input_enabled      = 1'b1;
    shadow_cfg.not_inverted       = 1'b1;
    shadow_cfg.active_high        = 1'b0;
    shadow_cfg.long_press_tenths  = 8'd10;
    shadow_cfg.door_debounce_ms   = 16'd200;
    shadow_cfg.switch_debounce_ms = 16'd100;
    shadow_cfg.key_debounce_ms    = 16'd50;
    key_press_start  = 32'd0;
    key_count        = 8'd0;
    key_last_long    = 32'd0;
    key_stable_level = 1'b0;
  endfunction

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      CFG_INPUT_MODE:      shadow_cfg.input_mode         = kied_mode_t'(val[1:0]);
      CFG_INPUT_ENABLED:   shadow_cfg.input_enabled      = val[0];
      CFG_NOT_INVERTED:    shadow_cfg.not_inverted       = val[0];
      CFG_ACTIVE_HIGH:     shadow_cfg.active_high        = val[0];
      CFG_LONG_PRESS:      shadow_cfg.long_press_tenths  = val[7:0];
      CFG_DOOR_DEBOUNCE:   shadow_cfg.door_debounce_ms   = val;
      CFG_SWITCH_DEBOUNCE: shadow_cfg.switch_debounce_ms = val;
      CFG_KEY_DEBOUNCE:    shadow_cfg.key_debounce_ms    = val;
      default: ;
    endcase
  endfunction

  // one sample in, at most one key event out; state is advanced in place
  function automatic bit predict_key_event(input kied_sample_t s, output kied_evt_t ev);
    logic        lvl;
    logic [31:0] now;
    logic [31:0] since_press;
    logic [31:0] since_long;
    logic [31:0] long_ms;
    logic [7:0]  tenths;
    bit          fire;
    ev = '0;
    ev.channel_out = s.channel_in;
    // locked channel: sample dropped, nothing moves
    if (!shadow_cfg.input_enabled) return 1'b0;
    // zero marks "none" in the state, so a zero timestamp reads as 1
    now = (s.time_ms == 32'd0) ? 32'd1 : s.time_ms;
    lvl = s.raw_level ^ ~shadow_cfg.not_inverted ^ shadow_cfg.active_high;
    since_press = now - key_press_start;
    since_long  = now - key_last_long;
    case (shadow_cfg.input_mode)
      MODE_DOOR: begin
        if (lvl != key_stable_level) begin
          if (key_press_start == 32'd0) begin
            key_press_start = now;
          end else if (since_press >= {16'd0, shadow_cfg.door_debounce_ms}) begin
            // counter fix-up sticks even when the bus is busy
            if ((key_count & LOW6_MASK) == 8'd0) key_count = 8'd1;
            if (!s.bus_blocked) begin
              ev.key_number    = key_count;
              ev.long_press    = ~lvl;
              key_count        = key_count + 8'd1;
              key_stable_level = lvl;
              return 1'b1;
            end
          end
        end else begin
          key_press_start = 32'd0;
        end
      end
      MODE_SWITCH: begin
        if (lvl) begin
          if (key_press_start == 32'd0) begin
            key_press_start = now;
          end else if (since_press >= {16'd0, shadow_cfg.switch_debounce_ms} &&
                       key_last_long == 32'd0) begin
            key_count     = key_count + 8'd1;
            key_last_long = now;
            ev.key_number = key_count;
            return 1'b1;
          end
        end else begin
          key_press_start = 32'd0;
          if (key_last_long != 32'd0) begin
            key_count     = key_count + 8'd1;
            key_last_long = 32'd0;
            ev.key_number = key_count;
            return 1'b1;
          end
        end
      end
      MODE_PUSH: begin
        if (lvl) begin
          // release: short event only if held long enough and no long event went out
          if (key_press_start != 32'd0) begin
            fire = since_press >= {16'd0, shadow_cfg.key_debounce_ms} &&
                   key_last_long == 32'd0;
            key_press_start = 32'd0;
            if (fire) begin
              key_count     = key_count + 8'd1;
              ev.key_number = key_count;
              return 1'b1;
            end
          end
        end else if (key_press_start != 32'd0) begin
          tenths  = (shadow_cfg.long_press_tenths == LP_SENTINEL) ?
                    LP_SUBST : shadow_cfg.long_press_tenths;
          long_ms = {24'd0, tenths} * 32'(TENTH_MS);
          if (key_last_long != 32'd0) begin
            // held on: repeat the long event with the same number
            if (since_long >= REPEAT_MS) begin
              key_last_long = now;
              ev.key_number = key_count;
              ev.long_press = 1'b1;
              return 1'b1;
            end
          end else if (since_press >= long_ms) begin
            key_count     = key_count + 8'd1;
            key_last_long = now;
            ev.key_number = key_count;
            ev.long_press = 1'b1;
            return 1'b1;
          end
        end else begin
          key_press_start = now;
          key_last_long   = 32'd0;
        end
      end
      MODE_MOTION: begin
        if (lvl) begin
          if (key_press_start == 32'd0) begin
            key_press_start = now;
          end else if (since_press >= {16'd0, shadow_cfg.switch_debounce_ms} &&
                       key_last_long == 32'd0) begin
            if ((key_count & LOW6_MASK) == 8'd0) key_count = 8'd1;
            if (!s.bus_blocked) begin
              ev.key_number = key_count;
              key_count     = key_count + 8'd1;
              key_last_long = now;
              return 1'b1;
            end
          end
        end else begin
          key_last_long   = 32'd0;
          key_press_start = 32'd0;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // all three channels are watched at the same edge, on pre-edge values
  always @(posedge clk) begin
    kied_evt_t got;
    kied_evt_t want;
    kied_evt_t next_evt;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        shadow_write(cfg_if.data.index, cfg_if.data.data);
      end
      if (evt_if.valid && evt_if.ready) begin
        got = evt_if.data;
        if (pending_events.size() == 0) begin
          report_error($sformatf("unexpected event ch=%0d num=%0d long=%0b",
                                 got.channel_out, got.key_number, got.long_press));
        end else begin
          want = pending_events.pop_front();
          if (got.channel_out !== want.channel_out)
            report_error($sformatf("channel_out got %0d want %0d",
                                   got.channel_out, want.channel_out));
          if (got.key_number !== want.key_number)
            report_error($sformatf("key_number got %0d want %0d",
                                   got.key_number, want.key_number));
          if (got.long_press !== want.long_press)
            report_error($sformatf("long_press got %0b want %0b",
                                   got.long_press, want.long_press));
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        if (predict_key_event(sample_if.data, next_evt)) pending_events.push_back(next_evt);
      end
      // watchdog: any transfer restarts the count
      if ((sample_if.valid && sample_if.ready) || (evt_if.valid && evt_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t watchdog: no transfer for %0d cycles, %0d events outstanding",
                   $time, idle_cycles, pending_events.size());
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_key(input logic raw, input logic [31:0] t, input logic [7:0] ch,
                          input logic busy);
    kied_sample_t s;
    s.raw_level   = raw;
    s.time_ms     = t;
    s.channel_in  = ch;
    s.bus_blocked = busy;
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    do @(posedge clk); while (sample_if.ready !== 1'b1);
  endtask

  // sender holds off until every predicted event has come back
  task automatic wait_events_drained();
    sample_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    kied_cfg_wr_t w;
    w.index = idx;
    w.data  = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  // samples that raise no event may still sit in the pipe, so let it settle
  task automatic apply_config(input kied_cfg_t c);
    wait_events_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_INPUT_MODE,      {14'd0, c.input_mode});
    write_reg(CFG_INPUT_ENABLED,   {15'd0, c.input_enabled});
    write_reg(CFG_NOT_INVERTED,    {15'd0, c.not_inverted});
    write_reg(CFG_ACTIVE_HIGH,     {15'd0, c.active_high});
    write_reg(CFG_LONG_PRESS,      {8'd0, c.long_press_tenths});
    write_reg(CFG_DOOR_DEBOUNCE,   c.door_debounce_ms);
    write_reg(CFG_SWITCH_DEBOUNCE, c.switch_debounce_ms);
    write_reg(CFG_KEY_DEBOUNCE,    c.key_debounce_ms);
    cfg_if.valid <= 1'b0;
    cur_cfg = c;
  endtask

  // rotate through: no idling, sender gaps, receiver stalls, both
  task automatic next_idle_pattern();
    case (idle_phase % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
    endcase
    idle_phase++;
  endtask

  // debounce times mostly in reach of the timestamp steps, sometimes extreme
  function automatic logic [15:0] random_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 16'd0;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom_range(400, 20));
  endfunction

  function automatic logic [7:0] random_tenths();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return LP_SENTINEL;
    if (r < 15) return 8'd0;
    if (r < 20) return 8'd254;
    return 8'($urandom_range(20, 1));
  endfunction

  function automatic kied_cfg_t random_cfg(input kied_mode_t mode);
    kied_cfg_t c;
    c.input_mode         = mode;
    c.input_enabled      = 1'b1;
    c.not_inverted       = 1'($urandom_range(1));
    c.active_high        = 1'($urandom_range(1));
    c.long_press_tenths  = random_tenths();
    c.door_debounce_ms   = random_ms();
    c.switch_debounce_ms = random_ms();
    c.key_debounce_ms    = random_ms();
    return c;
  endfunction

  // mostly coherent key activity: a level that holds for a while and a
  // timestamp that moves forward; a tenth of the samples are pure noise
  task automatic run_random_phase(input int unsigned n);
    int unsigned i;
    int unsigned r;
    logic [31:0] step;
    next_idle_pattern();
    // start near the 32-bit wrap now and then
    stamp_ms = ($urandom_range(99) < 30) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        send_key(1'($urandom_range(1)), $urandom(), 8'($urandom_range(255)),
                 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(99) < 30) pin_level = ~pin_level;
        r = $urandom_range(99);
        if (r < 10)      step = 32'd0;
        else if (r < 50) step = $urandom_range(60, 1);
        else if (r < 85) step = $urandom_range(500, 60);
        else if (r < 95) step = $urandom_range(3000, 500);
        else             step = $urandom_range(70000, 30000);
        stamp_ms = stamp_ms + step;
        send_key(pin_level, stamp_ms, 8'($urandom_range(255)), $urandom_range(99) < 25);
      end
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) wait_events_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // door mode from reset: counter of zero fixed to 1, busy bus holds the event
  task automatic test_door_sensor();
    cur_cfg.input_mode = MODE_DOOR;
    apply_config(cur_cfg);
    send_key(1'b1, 32'd5000, 8'h00, 1'b0);
    send_key(1'b1, 32'd5300, 8'hFF, 1'b1);
    send_key(1'b1, 32'd5301, 8'hFF, 1'b0);
    send_key(1'b0, 32'd5400, 8'h5A, 1'b0);
  endtask

  // default long press and key debounce: short press, too-short press,
  // long press with repeat, and a zero timestamp
  task automatic test_pushbutton();
    cur_cfg.input_mode = MODE_PUSH;
    apply_config(cur_cfg);
    send_key(1'b1, 32'd0,    8'h01, 1'b0);
    send_key(1'b0, 32'd0,    8'h02, 1'b1);
    send_key(1'b1, 32'd60,   8'h03, 1'b1);
    send_key(1'b0, 32'd100,  8'h04, 1'b0);
    send_key(1'b1, 32'd120,  8'h05, 1'b0);
    send_key(1'b0, 32'd200,  8'h06, 1'b0);
    send_key(1'b0, 32'd1200, 8'h07, 1'b1);
    send_key(1'b0, 32'd1400, 8'h08, 1'b0);
    send_key(1'b0, 32'd1500, 8'hFF, 1'b0);
    send_key(1'b1, 32'd1600, 8'h00, 1'b0);
  endtask

  // switch events on both edges, busy ignored; motion held by busy bus
  task automatic test_switch_and_motion();
    cur_cfg.input_mode = MODE_SWITCH;
    apply_config(cur_cfg);
    send_key(1'b0, 32'd10050, 8'h11, 1'b0);
    send_key(1'b1, 32'd10100, 8'h12, 1'b1);
    send_key(1'b1, 32'd10250, 8'h13, 1'b1);
    send_key(1'b0, 32'd10300, 8'h14, 1'b0);
    cur_cfg.input_mode = MODE_MOTION;
    apply_config(cur_cfg);
    send_key(1'b1, 32'd11000, 8'h21, 1'b0);
    send_key(1'b1, 32'd11100, 8'h22, 1'b1);
    send_key(1'b1, 32'd11101, 8'h23, 1'b0);
    send_key(1'b0, 32'd11200, 8'h24, 1'b0);
  endtask

  // locked channel drops samples and keeps its state
  task automatic test_channel_lock();
    cur_cfg.input_enabled = 1'b0;
    apply_config(cur_cfg);
    send_key(1'b0, 32'd20000, 8'h31, 1'b0);
    send_key(1'b1, 32'd20500, 8'h32, 1'b0);
    cur_cfg.input_enabled = 1'b1;
    apply_config(cur_cfg);
  endtask

  task automatic test_random_modes();
    int unsigned m;
    int unsigned p;
    for (m = 0; m < 4; m++) begin
      for (p = 0; p < 2; p++) begin
        apply_config(random_cfg(kied_mode_t'(m)));
        run_random_phase(PHASE_ITEMS);
      end
    end
  endtask

  // every timing register at its top value, then all at zero
  task automatic test_timing_extremes();
    kied_cfg_t c;
    c = random_cfg(kied_mode_t'($urandom_range(3)));
    c.long_press_tenths  = 8'd254;
    c.door_debounce_ms   = 16'hFFFF;
    c.switch_debounce_ms = 16'hFFFF;
    c.key_debounce_ms    = 16'hFFFF;
    apply_config(c);
    run_random_phase(PHASE_ITEMS);
    c = random_cfg(kied_mode_t'($urandom_range(3)));
    c.long_press_tenths  = 8'd0;
    c.door_debounce_ms   = 16'd0;
    c.switch_debounce_ms = 16'd0;
    c.key_debounce_ms    = 16'd0;
    apply_config(c);
    run_random_phase(PHASE_ITEMS);
  endtask

  // mode changes carry state across; now and then the channel is locked
  task automatic test_random_mixed();
    kied_cfg_t c;
    int unsigned p;
    for (p = 0; p < 3; p++) begin
      c = random_cfg(kied_mode_t'($urandom_range(3)));
      c.input_enabled = ($urandom_range(99) >= 20);
      apply_config(c);
      run_random_phase(c.input_enabled ? PHASE_ITEMS : LOCKED_ITEMS);
    end
    c = random_cfg(kied_mode_t'($urandom_range(3)));
    apply_config(c);
  endtask

  initial begin
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    reset_key_model();
    cur_cfg = shadow_cfg;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_door_sensor();
    test_pushbutton();
    test_switch_and_motion();
    test_channel_lock();
    test_random_modes();
    test_timing_extremes();
    test_random_mixed();

    wait_events_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      report_error($sformatf("%0d events never arrived", pending_events.size()));
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
